>>> src/lgs_pkg.sv
// Package with the shared types and constants of the Life generation engine.
package lgs_pkg;

   localparam int KIND_W  = 1;
   localparam int INDEX_W = 5;
   localparam int CELLS_W = 20;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
   localparam logic [KIND_W-1:0] KIND_ADVANCE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_CALC
   } seq_state_type;

endpackage

>>> src/life_req_if.sv
// Request channel interface: load or advance words going into the engine.
interface life_req_if;
   logic                           valid;
   logic                           ready;
   logic [lgs_pkg::KIND_W-1:0]     kind;
   logic [lgs_pkg::INDEX_W-1:0]    row_index;
   logic [lgs_pkg::CELLS_W-1:0]    row_cells;

   modport source (output valid, kind, row_index, row_cells, input ready);
   modport sink   (input valid, kind, row_index, row_cells, output ready);
endinterface

>>> src/life_rsp_if.sv
// Response channel interface: one word for each row of a new generation.
interface life_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lgs_pkg::INDEX_W-1:0]    out_row_index;
   logic [lgs_pkg::CELLS_W-1:0]    out_row_cells;
   logic                           last_row;

   modport source (output valid, out_row_index, out_row_cells, last_row, input ready);
   modport sink   (input valid, out_row_index, out_row_cells, last_row, output ready);
endinterface

>>> src/lgs_grid_mem.sv
// Grid memory: one row per entry, registered read, per-row valid bits for reset.
module lgs_grid_mem #(
   parameter int ROWS = 20,
   parameter int COLS = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [$clog2(ROWS)-1:0] wr_addr,
   input  logic [COLS-1:0]         wr_data,
   input  logic                    rd_en,
   input  logic [$clog2(ROWS)-1:0] rd_addr,
   output logic [COLS-1:0]         rd_data
);

   logic [COLS-1:0] mem [ROWS];
   logic [ROWS-1:0] row_valid_ff;
   logic [COLS-1:0] rdata_ff;
   logic            rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // A row never written since reset reads as all dead.
   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

>>> src/lgs_rule.sv
// Life rule for one row: neighbor counts and survive/birth decision per column.
module lgs_rule #(
   parameter int COLS = 20
) (
   input  logic [COLS-1:0] up_row,
   input  logic [COLS-1:0] mid_row,
   input  logic [COLS-1:0] dn_row,
   output logic [COLS-1:0] next_row
);

   logic [COLS+1:0] up_pad;
   logic [COLS+1:0] mid_pad;
   logic [COLS+1:0] dn_pad;

   // Dead cells are padded on both sides so that edges do not wrap.
   assign up_pad  = {1'b0, up_row, 1'b0};
   assign mid_pad = {1'b0, mid_row, 1'b0};
   assign dn_pad  = {1'b0, dn_row, 1'b0};

   for (genvar c = 0; c < COLS; c++) begin : g_col
      logic [3:0] count;
      assign count = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
                   + 4'(mid_pad[c]) + 4'(mid_pad[c+2])
                   + 4'(dn_pad[c]) + 4'(dn_pad[c+1]) + 4'(dn_pad[c+2]);
      assign next_row[c] = (count == 4'd3) || (mid_row[c] && (count == 4'd2));
   end

endmodule

>>> src/life_generation_step.sv
// Top level of the Life generation engine: sequencer, output register, grid memory and rule.
//
//   channel  dir  word
//   req_ch   in   kind, row_index, row_cells (load one row or advance)
//   rsp_ch   out  out_row_index, out_row_cells, last_row (one per new row)
//
// A load writes its row into the grid memory as it is taken. An advance issues
// the first read from ST_IDLE, primes the row window in ST_FILL, then puts out
// one row per cycle in ST_CALC while rsp_ch is not stalled, limited by the single
// read port of the grid memory. Reset clears the per-row valid bits, so the grid
// reads as all dead at once. A stalled rsp_ch holds the sweep on its current row;
// requests are taken only between sweeps.
module life_generation_step #(
   parameter int ROWS = 20,
   parameter int COLS = 20
) (
   input  logic       clock,
   input  logic       reset,
   life_req_if.sink   req_ch,
   life_rsp_if.source rsp_ch
);

   localparam int RowAW = $clog2(ROWS);

   lgs_pkg::seq_state_type state_ff, state_in;
   logic [RowAW-1:0]               r_ff, r_in;
   logic [COLS-1:0]                up_ff, up_in;
   logic [COLS-1:0]                mid_ff, mid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lgs_pkg::INDEX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [lgs_pkg::CELLS_W-1:0]    rsp_cells_ff, rsp_cells_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           wr_en;
   logic [RowAW-1:0]               wr_addr;
   logic [COLS-1:0]                wr_data;
   logic                           rd_en;
   logic [RowAW-1:0]               rd_addr;
   logic [COLS-1:0]                rd_data;
   logic [COLS-1:0]                dn_row;
   logic [COLS-1:0]                next_row;

   logic                           is_last;
   logic                           slot_free;
   logic                           load_in_range;
   logic [RowAW-1:0]               load_addr;
   logic [COLS-1:0]                load_cells;
   logic [RowAW:0]                 read_ahead;
   logic [RowAW+lgs_pkg::INDEX_W-1:0] load_addr_ext;
   logic [COLS+lgs_pkg::CELLS_W-1:0]  load_cells_ext;
   logic [RowAW+lgs_pkg::INDEX_W-1:0] out_idx_ext;
   logic [COLS+lgs_pkg::CELLS_W-1:0]  out_cells_ext;

   assign is_last        = (r_ff == RowAW'(ROWS - 1));
   assign slot_free      = !rsp_valid_ff || rsp_ch.ready;
   assign load_in_range  = (7'(req_ch.row_index) < 7'(ROWS));
   assign load_addr_ext  = {{RowAW{1'b0}}, req_ch.row_index};
   assign load_addr      = load_addr_ext[RowAW-1:0];
   // Bits beyond the last column are dropped.
   assign load_cells_ext = {{COLS{1'b0}}, req_ch.row_cells};
   assign load_cells     = load_cells_ext[COLS-1:0];
   assign read_ahead     = (RowAW+1)'(r_ff) + (RowAW+1)'(2);
   assign dn_row         = is_last ? '0 : rd_data;
   assign out_idx_ext    = {{lgs_pkg::INDEX_W{1'b0}}, r_ff};
   assign out_cells_ext  = {{lgs_pkg::CELLS_W{1'b0}}, next_row};

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_cells_in = rsp_cells_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = r_ff;
      wr_data      = next_row;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         lgs_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.kind == lgs_pkg::KIND_LOAD) begin
                  wr_en   = load_in_range;
                  wr_addr = load_addr;
                  wr_data = load_cells;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = lgs_pkg::ST_FILL;
               end
            end
         end
         lgs_pkg::ST_FILL: begin
            // Row 0 arrives now; the row above it lies outside the grid.
            up_in    = '0;
            mid_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = RowAW'(1);
            r_in     = '0;
            state_in = lgs_pkg::ST_CALC;
         end
         lgs_pkg::ST_CALC: begin
            if (slot_free) begin
               // The old row r stays in the window, so writing the new one back is safe.
               wr_en        = 1'b1;
               wr_addr      = r_ff;
               wr_data      = next_row;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = out_idx_ext[lgs_pkg::INDEX_W-1:0];
               rsp_cells_in = out_cells_ext[lgs_pkg::CELLS_W-1:0];
               rsp_last_in  = is_last;
               up_in        = mid_ff;
               mid_in       = dn_row;
               if (is_last) begin
                  state_in = lgs_pkg::ST_IDLE;
               end else begin
                  r_in = r_ff + RowAW'(1);
                  if (read_ahead < (RowAW+1)'(ROWS)) begin
                     rd_en   = 1'b1;
                     rd_addr = read_ahead[RowAW-1:0];
                  end
               end
            end
         end
         default: begin
            state_in = lgs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         r_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         r_ff         <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff        <= up_in;
      mid_ff       <= mid_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_cells_ff <= rsp_cells_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ch.ready         = (state_ff == lgs_pkg::ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_row_index = rsp_idx_ff;
   assign rsp_ch.out_row_cells = rsp_cells_ff;
   assign rsp_ch.last_row      = rsp_last_ff;

   lgs_grid_mem #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_grid_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lgs_rule #(
      .COLS (COLS)
   ) u_rule (
      .up_row   (up_ff),
      .mid_row  (mid_ff),
      .dn_row   (dn_row),
      .next_row (next_row)
   );

endmodule

>>> test/life_generation_step_tb.sv
// Self-checking testbench for the Life generation engine with its own row predictor.
`timescale 1ns / 100ps

module life_generation_step_tb;

   localparam int GRID_ROWS    = 20;
   localparam int GRID_COLS    = 20;
   localparam int MAX_GAP      = 5;
   localparam int RANDOM_WORDS = 360;
   localparam int SETTLE_CYCLES = GRID_ROWS + 10;

   typedef logic [lgs_pkg::KIND_W-1:0]  kind_type;
   typedef logic [lgs_pkg::INDEX_W-1:0] row_index_type;
   typedef logic [lgs_pkg::CELLS_W-1:0] row_bits_type;

   typedef struct packed {
      logic [lgs_pkg::INDEX_W-1:0] row_index;
      logic [lgs_pkg::CELLS_W-1:0] row_cells;
      logic                        last_row;
   } gen_row_type;

   logic clock = 1'b0;
   logic reset;

   life_req_if req_ch ();
   life_rsp_if rsp_ch ();

   life_generation_step #(
      .ROWS (GRID_ROWS),
      .COLS (GRID_COLS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   // Predicted grid and the rows of each new generation still to come out.
   row_bits_type life_grid [GRID_ROWS];
   gen_row_type  pending_rows [$];

   bit calm_mode = 1'b0;
   int rsp_wait  = 0;
   int words_sent, loads_sent, stray_loads, advances_sent, rows_checked, fail_count;

   function automatic int draw_gap();
      return calm_mode ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic row_bits_type random_cells();
      case ($urandom_range(0, 5))
         0: return row_bits_type'($urandom & $urandom & $urandom);
         1: return row_bits_type'($urandom);
         2: return row_bits_type'($urandom | $urandom);
         3: return '1;
         4: return '0;
         default: return row_bits_type'(1) << $urandom_range(0, GRID_COLS - 1);
      endcase
   endfunction

   // Computes the next generation with dead cells beyond every edge and queues its rows.
   task automatic predict_generation();
      row_bits_type next_grid [GRID_ROWS];
      int           rr, cc, live_count;
      gen_row_type  word;
      for (int r = 0; r < GRID_ROWS; r++) begin
         next_grid[r] = '0;
         for (int c = 0; c < GRID_COLS; c++) begin
            live_count = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  rr = r + dr;
                  cc = c + dc;
                  if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS &&
                      cc >= 0 && cc < GRID_COLS && life_grid[rr][cc])
                     live_count++;
               end
            end
            if (life_grid[r][c] ? (live_count == 2 || live_count == 3) : (live_count == 3))
               next_grid[r][c] = 1'b1;
         end
      end
      for (int r = 0; r < GRID_ROWS; r++) begin
         life_grid[r]   = next_grid[r];
         word.row_index = row_index_type'(r);
         word.row_cells = next_grid[r];
         word.last_row  = (r == GRID_ROWS - 1);
         pending_rows.push_back(word);
      end
   endtask

   // Offers one word after a random gap, waits for it to be taken, then updates the predicted grid.
   task automatic send_word(input kind_type kind, input row_index_type idx,
                            input row_bits_type cells);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= kind;
      req_ch.row_index <= idx;
      req_ch.row_cells <= cells;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (kind == lgs_pkg::KIND_ADVANCE) begin
         advances_sent++;
         predict_generation();
      end else begin
         loads_sent++;
         if (idx < GRID_ROWS)
            life_grid[idx] = cells;
         else
            stray_loads++;
      end
   endtask

   task automatic load_row(input int idx, input row_bits_type cells);
      send_word(lgs_pkg::KIND_LOAD, row_index_type'(idx), cells);
   endtask

   task automatic advance();
      send_word(lgs_pkg::KIND_ADVANCE, row_index_type'($urandom), row_bits_type'($urandom));
   endtask

   // Holds the request side idle until every predicted row has been seen.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_rows.size() != 0);
   endtask

   task automatic test_empty_grid();
      advance();
   endtask

   task automatic test_full_edge_rows();
      load_row(0, '1);
      load_row(GRID_ROWS - 1, '1);
      load_row(9, 20'h80001);
      advance();
   endtask

   // Loads aimed past the last row must leave the grid untouched.
   task automatic test_out_of_range_load();
      wait_drained();
      load_row(GRID_ROWS, '1);
      load_row(31, 20'h5A5A5);
      load_row(24, '1);
      advance();
   endtask

   task automatic test_known_patterns();
      load_row(0, 20'h00003);
      load_row(1, 20'h00003);
      load_row(18, 20'hE0000);
      load_row(5, 20'h00040);
      load_row(6, 20'h00080);
      load_row(7, 20'h000E0);
      repeat (3) advance();
   endtask

   // Mostly batches of row loads followed by a few advances, with some noise words.
   task automatic test_random_sequences();
      int stop_at, mode, n_loads, idx;
      stop_at = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         calm_mode = ($urandom_range(0, 7) == 0);
         mode      = $urandom_range(0, 9);
         if (mode == 0) begin
            repeat ($urandom_range(1, 6))
               send_word(kind_type'($urandom), row_index_type'($urandom), random_cells());
         end else begin
            if (mode == 1) begin
               for (int r = 0; r < GRID_ROWS; r++)
                  load_row(r, random_cells());
            end else begin
               n_loads = $urandom_range(1, 12);
               for (int k = 0; k < n_loads; k++) begin
                  idx = ($urandom_range(0, 9) == 0) ? $urandom_range(GRID_ROWS, 31)
                                                   : $urandom_range(0, GRID_ROWS - 1);
                  load_row(idx, random_cells());
               end
            end
            repeat ($urandom_range(1, 3)) advance();
         end
         if (mode == 9)
            wait_drained();
      end
      calm_mode = 1'b0;
   endtask

   // Response side: checks each accepted row and draws a new stall after it.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rows.size() == 0) begin
            $error("unexpected row word: index %0d cells %05h", rsp_ch.out_row_index,
                   rsp_ch.out_row_cells);
            fail_count++;
         end else begin
            gen_row_type want;
            want = pending_rows.pop_front();
            if (rsp_ch.out_row_index !== want.row_index) begin
               $error("out_row_index: expected %0d, got %0d", want.row_index,
                      rsp_ch.out_row_index);
               fail_count++;
            end
            if (rsp_ch.out_row_cells !== want.row_cells) begin
               $error("out_row_cells: expected %05h, got %05h", want.row_cells,
                      rsp_ch.out_row_cells);
               fail_count++;
            end
            if (rsp_ch.last_row !== want.last_row) begin
               $error("last_row: expected %0d, got %0d", want.last_row, rsp_ch.last_row);
               fail_count++;
            end
         end
         rows_checked++;
         rsp_wait = draw_gap();
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_ch.ready <= (rsp_wait == 0);
   end

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.kind      <= lgs_pkg::KIND_LOAD;
      req_ch.row_index <= '0;
      req_ch.row_cells <= '0;
      for (int r = 0; r < GRID_ROWS; r++)
         life_grid[r] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_grid();
      test_full_edge_rows();
      test_out_of_range_load();
      test_known_patterns();
      test_random_sequences();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d words: %0d row loads (%0d outside the grid) and %0d advances.",
               words_sent, loads_sent, stray_loads, advances_sent);
      $display("Checked %0d generated rows, %0d still pending.", rows_checked,
               pending_rows.size());
      if (fail_count == 0 && pending_rows.size() == 0) begin
         $display("life_generation_step_tb OK");
      end else begin
         $display("life_generation_step_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("life_generation_step_tb NOT OK");
      $finish;
   end

endmodule

>>> files.f
src/lgs_pkg.sv
src/life_req_if.sv
src/life_rsp_if.sv
src/lgs_grid_mem.sv
src/lgs_rule.sv
src/life_generation_step.sv
test/life_generation_step_tb.sv
